// ===== src/kcq_pkg.sv =====
// shared types and constants for the k-means color quantizer
package kcq_pkg;

  localparam int MaxCenters = 16;
  localparam int IdxW = 4;
  localparam int MaxPixels = 1048576;
  localparam int CntW = 21;
  localparam int SumW = 28;
  localparam int DistW = 18;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_END = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ACCUM,
    ST_DIV,
    ST_EMIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic search_start;
    logic search_step;
    logic accum;
    logic div_start;
    logic emit;
    logic clear_sums;
    logic [IdxW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

// ===== src/kcq_datapath.sv =====
// center store, distance search, accumulators and divider
module kcq_datapath (
  input  logic clk,
  input  logic rst_n,
  input  kcq_pkg::cmd_t cmd,
  output kcq_pkg::sts_t sts,
  input  logic [3:0] in_idx,
  input  logic [7:0] in_r,
  input  logic [7:0] in_g,
  input  logic [7:0] in_b,
  output logic [3:0] res_idx,
  output logic [23:0] res_color,
  output logic res_ovf
);

  logic [23:0] center_r [kcq_pkg::MaxCenters];
  logic [kcq_pkg::SumW-1:0] rsum_r [kcq_pkg::MaxCenters];
  logic [kcq_pkg::SumW-1:0] gsum_r [kcq_pkg::MaxCenters];
  logic [kcq_pkg::SumW-1:0] bsum_r [kcq_pkg::MaxCenters];
  logic [kcq_pkg::CntW-1:0] cnt_r [kcq_pkg::MaxCenters];
  logic ovf_r;
  logic [7:0] pr_r, pg_r, pb_r;
  logic [3:0] best_r;
  logic [kcq_pkg::DistW-1:0] best_d_r;
  logic best_valid_r;

  logic [23:0] cc;
  logic [7:0] dr, dg, db;
  logic [kcq_pkg::DistW-1:0] sq_dist;
  assign cc = center_r[cmd.idx];
  assign dr = (pr_r > cc[23:16]) ? pr_r - cc[23:16] : cc[23:16] - pr_r;
  assign dg = (pg_r > cc[15:8]) ? pg_r - cc[15:8] : cc[15:8] - pg_r;
  assign db = (pb_r > cc[7:0]) ? pb_r - cc[7:0] : cc[7:0] - pb_r;
  assign sq_dist = kcq_pkg::DistW'({8'b0, dr} * {8'b0, dr})
                 + kcq_pkg::DistW'({8'b0, dg} * {8'b0, dg})
                 + kcq_pkg::DistW'({8'b0, db} * {8'b0, db});

  // restoring divider, three channels in parallel, one quotient bit per cycle
  logic [kcq_pkg::SumW-1:0] qr_r, qg_r, qb_r;
  logic [kcq_pkg::CntW:0] rr_r, rg_r, rb_r;
  logic [kcq_pkg::CntW-1:0] dv_r;
  logic [4:0] dcnt_r;
  logic dbusy_r;
  logic [kcq_pkg::CntW:0] tr, tg, tb;
  assign tr = {rr_r[kcq_pkg::CntW-1:0], qr_r[kcq_pkg::SumW-1]};
  assign tg = {rg_r[kcq_pkg::CntW-1:0], qg_r[kcq_pkg::SumW-1]};
  assign tb = {rb_r[kcq_pkg::CntW-1:0], qb_r[kcq_pkg::SumW-1]};
  assign sts.div_done = !dbusy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < kcq_pkg::MaxCenters; i++) begin
        center_r[i] <= '0;
        rsum_r[i] <= '0;
        gsum_r[i] <= '0;
        bsum_r[i] <= '0;
        cnt_r[i] <= '0;
      end
      ovf_r <= 1'b0;
      dbusy_r <= 1'b0;
      best_valid_r <= 1'b0;
    end else begin
      if (cmd.load_item) center_r[in_idx] <= {in_r, in_g, in_b};
      if (cmd.search_start) begin
        pr_r <= in_r;
        pg_r <= in_g;
        pb_r <= in_b;
        best_valid_r <= 1'b0;
      end
      if (cmd.search_step && (!best_valid_r || sq_dist < best_d_r)) begin
        best_valid_r <= 1'b1;
        best_d_r <= sq_dist;
        best_r <= cmd.idx;
      end
      if (cmd.accum) begin
        res_idx <= best_r;
        res_color <= center_r[best_r];
        if (cnt_r[best_r] >= kcq_pkg::CntW'(kcq_pkg::MaxPixels)) begin
          ovf_r <= 1'b1;
          res_ovf <= 1'b1;
        end else begin
          rsum_r[best_r] <= rsum_r[best_r] + kcq_pkg::SumW'(pr_r);
          gsum_r[best_r] <= gsum_r[best_r] + kcq_pkg::SumW'(pg_r);
          bsum_r[best_r] <= bsum_r[best_r] + kcq_pkg::SumW'(pb_r);
          cnt_r[best_r] <= cnt_r[best_r] + 1'b1;
          res_ovf <= ovf_r;
        end
      end
      if (cmd.div_start) begin
        qr_r <= rsum_r[cmd.idx];
        qg_r <= gsum_r[cmd.idx];
        qb_r <= bsum_r[cmd.idx];
        rr_r <= '0;
        rg_r <= '0;
        rb_r <= '0;
        dv_r <= cnt_r[cmd.idx];
        dcnt_r <= 5'(kcq_pkg::SumW - 1);
        dbusy_r <= (cnt_r[cmd.idx] != '0);
      end else if (dbusy_r) begin
        rr_r <= (tr >= {1'b0, dv_r}) ? tr - {1'b0, dv_r} : tr;
        rg_r <= (tg >= {1'b0, dv_r}) ? tg - {1'b0, dv_r} : tg;
        rb_r <= (tb >= {1'b0, dv_r}) ? tb - {1'b0, dv_r} : tb;
        qr_r <= {qr_r[kcq_pkg::SumW-2:0], tr >= {1'b0, dv_r}};
        qg_r <= {qg_r[kcq_pkg::SumW-2:0], tg >= {1'b0, dv_r}};
        qb_r <= {qb_r[kcq_pkg::SumW-2:0], tb >= {1'b0, dv_r}};
        dcnt_r <= dcnt_r - 1'b1;
        if (dcnt_r == '0) dbusy_r <= 1'b0;
      end
      if (cmd.emit) begin
        res_idx <= cmd.idx;
        res_ovf <= ovf_r;
        if (cnt_r[cmd.idx] != '0) begin
          center_r[cmd.idx] <= {qr_r[7:0], qg_r[7:0], qb_r[7:0]};
          res_color <= {qr_r[7:0], qg_r[7:0], qb_r[7:0]};
        end else begin
          res_color <= center_r[cmd.idx];
        end
      end
      if (cmd.clear_sums) begin
        for (int i = 0; i < kcq_pkg::MaxCenters; i++) begin
          rsum_r[i] <= '0;
          gsum_r[i] <= '0;
          bsum_r[i] <= '0;
          cnt_r[i] <= '0;
        end
        ovf_r <= 1'b0;
      end
    end
  end

endmodule

// ===== src/kcq_ctrl.sv =====
// controller state machine sequencing search, update and output
module kcq_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [1:0] in_kind,
  input  logic [4:0] k_cfg,
  input  logic out_tready,
  output logic out_tvalid,
  output logic res_kind,
  output logic res_last,
  output kcq_pkg::cmd_t cmd,
  input  kcq_pkg::sts_t sts
);

  kcq_pkg::state_t state_r, state_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic kind_r, kind_nxt, last_r, last_nxt, ov_r, ov_nxt;
  logic [4:0] k;
  logic [4:0] kl;

  assign kl = (k_cfg > 5'(kcq_pkg::MaxCenters)) ? 5'(kcq_pkg::MaxCenters) : k_cfg;
  assign k = (kl == '0) ? 5'd1 : kl;
  assign out_tvalid = ov_r;
  assign res_kind = kind_r;
  assign res_last = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kcq_pkg::ST_IDLE;
      idx_r <= '0;
      kind_r <= 1'b0;
      last_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      kind_r <= kind_nxt;
      last_r <= last_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    kind_nxt = kind_r;
    last_nxt = last_r;
    ov_nxt = ov_r && !out_tready;
    cmd = '0;
    cmd.idx = idx_r[3:0];
    in_tready = 1'b0;
    unique case (state_r)
      kcq_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_kind)
            kcq_pkg::KIND_LOAD: cmd.load_item = 1'b1;
            kcq_pkg::KIND_PIXEL: begin
              cmd.search_start = 1'b1;
              idx_nxt = '0;
              state_nxt = kcq_pkg::ST_SEARCH;
            end
            kcq_pkg::KIND_END: begin
              idx_nxt = '0;
              state_nxt = kcq_pkg::ST_DIV;
            end
            default: ;
          endcase
        end
      end
      kcq_pkg::ST_SEARCH: begin
        cmd.search_step = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r + 1'b1 == k) state_nxt = kcq_pkg::ST_ACCUM;
      end
      kcq_pkg::ST_ACCUM: begin
        // wait for the output register to drain before reusing it
        if (!ov_r || out_tready) begin
          cmd.accum = 1'b1;
          ov_nxt = 1'b1;
          kind_nxt = 1'b0;
          last_nxt = 1'b0;
          state_nxt = kcq_pkg::ST_IDLE;
        end
      end
      kcq_pkg::ST_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = kcq_pkg::ST_EMIT;
      end
      kcq_pkg::ST_EMIT: begin
        if (sts.div_done && (!ov_r || out_tready)) begin
          cmd.emit = 1'b1;
          ov_nxt = 1'b1;
          kind_nxt = 1'b1;
          last_nxt = (idx_r + 1'b1 == k);
          idx_nxt = idx_r + 1'b1;
          if (idx_r + 1'b1 == k) begin
            state_nxt = kcq_pkg::ST_OUT;
          end else begin
            state_nxt = kcq_pkg::ST_DIV;
          end
        end
      end
      kcq_pkg::ST_OUT: begin
        cmd.clear_sums = 1'b1;
        state_nxt = kcq_pkg::ST_IDLE;
      end
      default: state_nxt = kcq_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== src/kmeans_color_quantizer.sv =====
// top level of the k-means color quantizer
// One Lloyd k-means pass over RGB pixels.
// Input stream: tuser = kind (0 load center, 1 pixel, 2 end of pass),
//   tdata = load_slot, red, green, blue from bit 0 up.
// Output stream: tuser = result_kind, tlast = last of an end-of-pass run,
//   tdata = cluster_index, red, green, blue, overflow from bit 0 up.
// A load gives no result.
// A pixel is searched over the k active centers: the center store is read
//   once a cycle by one distance unit, then the sums are updated and the
//   assignment is registered for output.
// An end of pass emits k centers; each needs a bit-serial
//   divider run (skipped for an empty cluster).
// cluster_count is to be written through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
// Reset clears centers, sums, counts and overflow and sets k to 16.
// When the receiver stalls, the result holds in the output register and
//   the block waits before producing the next one.
module kmeans_color_quantizer (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [31:0] in_tdata,   // load_slot[3:0], red, green, blue
  input  logic [1:0] in_tuser,    // kind
  output logic out_tvalid,
  input  logic out_tready,
  output logic [31:0] out_tdata,  // cluster_index[3:0], red, green, blue, overflow
  output logic out_tuser,         // result_kind
  output logic out_tlast,
  input  logic cfg_wr_en,
  input  logic [4:0] cfg_wr_data
);

  logic [4:0] k_r;
  kcq_pkg::cmd_t cmd;
  kcq_pkg::sts_t sts;
  logic [3:0] res_idx;
  logic [23:0] res_color;
  logic res_ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) k_r <= 5'd16;
    else if (cfg_wr_en) k_r <= cfg_wr_data;
  end

  kcq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_kind(in_tuser),
    .k_cfg(k_r), .out_tready(out_tready), .out_tvalid(out_tvalid),
    .res_kind(out_tuser), .res_last(out_tlast), .cmd(cmd), .sts(sts)
  );

  kcq_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_idx(in_tdata[3:0]), .in_r(in_tdata[11:4]), .in_g(in_tdata[19:12]),
    .in_b(in_tdata[27:20]),
    .res_idx(res_idx), .res_color(res_color), .res_ovf(res_ovf)
  );

  assign out_tdata = {3'b000, res_ovf, res_color[7:0], res_color[15:8],
                      res_color[23:16], res_idx};

endmodule

// ===== src/kcq_checker.sv =====
// port-level checks for the quantizer, bound to the top level
module kcq_checker (
  input logic clk,
  input logic rst_n,
  input logic out_tvalid,
  input logic out_tready,
  input logic [31:0] out_tdata,
  input logic out_tuser,
  input logic out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser) else $error("last on pixel result");
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid after reset");

endmodule

bind kmeans_color_quantizer kcq_checker u_kcq_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
);

// ===== tb/sv/tb_kmeans_color_quantizer.sv =====
// testbench for the k-means color quantizer: directed and random requests against a predictor
`timescale 1ns / 100ps

module tb_kmeans_color_quantizer;

  typedef struct packed {
    logic       center_kind;
    logic [3:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       ovf;
    logic       last;
  } quant_result_t;

  class palette_scoreboard;
    logic [23:0] centers[16];
    logic [27:0] sum_r[16], sum_g[16], sum_b[16];
    logic [20:0] members[16];
    logic        ovf;
    logic [4:0]  k_reg;
    quant_result_t pending[$];
    int errors;
    int pixels, passes, loads;

    function void clear_pass();
      for (int i = 0; i < 16; i++) begin
        sum_r[i] = '0; sum_g[i] = '0; sum_b[i] = '0; members[i] = '0;
      end
      ovf = 1'b0;
    endfunction

    function void reset_state();
      for (int i = 0; i < 16; i++) centers[i] = '0;
      clear_pass();
      k_reg = 5'd16;
      errors = 0;
    endfunction

    function int active_k();
      if (k_reg < 1) return 1;
      if (k_reg > 16) return 16;
      return int'(k_reg);
    endfunction

    function quant_result_t make(logic ck, int i, logic lst);
      quant_result_t r;
      r.center_kind = ck;
      r.index = i[3:0];
      {r.red, r.green, r.blue} = centers[i];
      r.ovf = ovf;
      r.last = lst;
      return r;
    endfunction

    function void note_request(kcq_pkg::kind_t kind, logic [3:0] slot,
                               logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int k, best, d, dr, dg, db;
      int best_d;
      logic [27:0] nr, ng, nb;
      k = active_k();
      case (kind)
        kcq_pkg::KIND_LOAD: begin
          centers[slot] = {r, g, b};
          loads++;
        end
        kcq_pkg::KIND_PIXEL: begin
          best = 0;
          best_d = 32'h7fffffff;
          for (int i = 0; i < k; i++) begin
            dr = int'(r) - int'(centers[i][23:16]);
            dg = int'(g) - int'(centers[i][15:8]);
            db = int'(b) - int'(centers[i][7:0]);
            d = dr * dr + dg * dg + db * db;
            if (d < best_d) begin
              best_d = d;
              best = i;
            end
          end
          if (members[best] >= kcq_pkg::MaxPixels) ovf = 1'b1;
          else begin
            sum_r[best] += 28'(r); sum_g[best] += 28'(g); sum_b[best] += 28'(b);
            members[best] += 21'd1;
          end
          pending.push_back(make(1'b0, best, 1'b0));
          pixels++;
        end
        kcq_pkg::KIND_END: begin
          for (int i = 0; i < k; i++) begin
            if (members[i] != 0) begin
              nr = sum_r[i] / 28'(members[i]);
              ng = sum_g[i] / 28'(members[i]);
              nb = sum_b[i] / 28'(members[i]);
              centers[i] = {nr[7:0], ng[7:0], nb[7:0]};
            end
            pending.push_back(make(1'b1, i, i + 1 == k));
          end
          clear_pass();
          passes++;
        end
        default: ;
      endcase
    endfunction

    function void check_result(quant_result_t got);
      quant_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.center_kind != exp_r.center_kind) begin
        $error("result_kind exp %0d got %0d", exp_r.center_kind, got.center_kind); errors++;
      end
      if (got.index != exp_r.index) begin
        $error("cluster_index exp %0d got %0d", exp_r.index, got.index); errors++;
      end
      if (got.red != exp_r.red) begin
        $error("out_red exp %0d got %0d", exp_r.red, got.red); errors++;
      end
      if (got.green != exp_r.green) begin
        $error("out_green exp %0d got %0d", exp_r.green, got.green); errors++;
      end
      if (got.blue != exp_r.blue) begin
        $error("out_blue exp %0d got %0d", exp_r.blue, got.blue); errors++;
      end
      if (got.ovf != exp_r.ovf) begin
        $error("overflow exp %0d got %0d", exp_r.ovf, got.ovf); errors++;
      end
      if (got.last != exp_r.last) begin
        $error("last exp %0d got %0d", exp_r.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [31:0] in_tdata = 0;   // load_slot[3:0], red, green, blue
  logic [1:0] in_tuser = 0;    // kind
  logic out_tvalid;
  logic out_tready = 0;
  logic [31:0] out_tdata;      // cluster_index[3:0], red, green, blue, overflow
  logic out_tuser;             // result_kind
  logic out_tlast;
  logic cfg_wr_en = 0;
  logic [4:0] cfg_wr_data = 0;

  palette_scoreboard sb;
  bit long_hold = 0;
  int burst_left = 0;

  kmeans_color_quantizer DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #50_000_000;
    $display("tb_kmeans_color_quantizer: FAIL");
    $finish;
  end

  // receiver stall pattern, with one long hold-off on request
  int rx_phase = 0;
  always @(negedge clk) begin
    rx_phase <= rx_phase + 1;
    if (long_hold) out_tready <= 0;
    else if (rx_phase % 200 < 60) out_tready <= 1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    quant_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.center_kind = out_tuser;
      got.index = out_tdata[3:0];
      got.red = out_tdata[11:4];
      got.green = out_tdata[19:12];
      got.blue = out_tdata[27:20];
      got.ovf = out_tdata[28];
      got.last = out_tlast;
      sb.check_result(got);
    end
  end

  // returns right after the accepting edge; valid stays up for a following request
  task automatic send_request(kcq_pkg::kind_t kind, logic [3:0] slot,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
    end
    burst_left--;
    @(negedge clk);
    // random gap between bursts
    if (gap != 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= {4'b0, b, g, r, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(kind, slot, r, g, b);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  task automatic drain();
    release_input();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_k(logic [4:0] v);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 0;
    sb.k_reg = v;
  endtask

  task automatic rand_pixel();
    send_request(kcq_pkg::KIND_PIXEL, 4'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
  endtask

  initial begin
    kcq_pkg::kind_t kd;
    sb = new();
    sb.reset_state();
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, ties, empty cluster, ignored kind
    send_request(kcq_pkg::KIND_LOAD, 4'd0, 8'h00, 8'h00, 8'h00);
    send_request(kcq_pkg::KIND_LOAD, 4'd1, 8'hff, 8'hff, 8'hff);
    send_request(kcq_pkg::KIND_LOAD, 4'd15, 8'h80, 8'h80, 8'h80);
    send_request(kcq_pkg::KIND_PIXEL, 4'hf, 8'hff, 8'hff, 8'hff);
    send_request(kcq_pkg::KIND_PIXEL, 4'd0, 8'h00, 8'h00, 8'h00);
    send_request(kcq_pkg::KIND_PIXEL, 4'd0, 8'h40, 8'h40, 8'h40);
    send_request(kcq_pkg::KIND_PIXEL, 4'd0, 8'hc0, 8'hc0, 8'hc0);
    send_request(kcq_pkg::KIND_NONE, 4'ha, 8'h55, 8'haa, 8'h55);
    send_request(kcq_pkg::KIND_END, 4'd0, 8'd0, 8'd0, 8'd0);
    write_k(5'd1);
    send_request(kcq_pkg::KIND_PIXEL, 4'd0, 8'hff, 8'h00, 8'hff);
    send_request(kcq_pkg::KIND_END, 4'd0, 8'd0, 8'd0, 8'd0);
    write_k(5'd0);
    send_request(kcq_pkg::KIND_PIXEL, 4'd0, 8'h12, 8'h34, 8'h56);
    send_request(kcq_pkg::KIND_END, 4'd0, 8'd0, 8'd0, 8'd0);
    write_k(5'd31);
    send_request(kcq_pkg::KIND_LOAD, 4'd2, 8'h00, 8'h00, 8'h00);
    send_request(kcq_pkg::KIND_PIXEL, 4'd0, 8'h00, 8'h00, 8'h00);
    send_request(kcq_pkg::KIND_END, 4'd0, 8'd0, 8'd0, 8'd0);

    // random passes: load a random subset of the slots, a run of mostly pixels, end of pass
    for (int pass = 0; pass < 20; pass++) begin
      write_k(5'(pass % 5 == 0 ? 16 : (pass % 7 == 0 ? 1 : $urandom_range(0, 31))));
      for (int i = 0; i < 16; i++)
        if ($urandom_range(0, 3) != 0)
          send_request(kcq_pkg::KIND_LOAD, i[3:0], 8'($urandom), 8'($urandom),
                       8'($urandom));
      for (int i = $urandom_range(4, 16); i > 0; i--) begin
        if ($urandom_range(0, 15) == 0) begin
          kd = kcq_pkg::kind_t'($urandom_range(0, 3));
          if (kd == kcq_pkg::KIND_END) kd = kcq_pkg::KIND_NONE;
          send_request(kd, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else rand_pixel();
      end
      if (pass == 12) drain();
      send_request(kcq_pkg::KIND_END, 4'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom));
    end
    // hold-off counted in cycles while the sender keeps offering
    fork
      begin
        long_hold = 1;
        repeat (400) @(negedge clk);
        long_hold = 0;
      end
      begin
        for (int i = 0; i < 20; i++) rand_pixel();
        release_input();
      end
    join
    send_request(kcq_pkg::KIND_END, 4'd0, 8'd0, 8'd0, 8'd0);

    drain();
    $display("covered %0d loads, %0d pixels and %0d end-of-pass runs",
             sb.loads, sb.pixels, sb.passes);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_kmeans_color_quantizer: PASS");
    else
      $display("tb_kmeans_color_quantizer: FAIL");
    $finish;
  end

endmodule
